@@ sv/ccm_pkg.sv @@
// Shared types and constants of the cluster moments block.
// Used by every module of the block; depends on nothing.
package ccm_pkg;

  // Hit limit per cluster, default for the top level parameter
  localparam int unsigned MaxHitsDef = 64;

  // Cluster queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QCountW    = $clog2(QueueDepth + 1);

  // Arithmetic unit widths
  localparam int unsigned MulW  = 48;
  localparam int unsigned HalfW = MulW / 2;
  localparam int unsigned ProdW = 2 * MulW;
  localparam int unsigned NumW  = 72;
  localparam int unsigned DenW  = 46;
  localparam int unsigned QuoW  = 26;

  // Quotient lengths of the three divisions
  localparam logic [4:0] QCentroid = 5'd13;
  localparam logic [4:0] QBalance  = 5'd17;
  localparam logic [4:0] QSpread   = 5'd26;

  localparam logic [11:0] HalfWidthRst = 12'd224;

  // Configuration register indexes
  typedef enum logic {
    CFG_THRESHOLD  = 1'b0,
    CFG_HALF_WIDTH = 1'b1
  } cfg_idx_e;

  // Closed cluster handed from front to back
  typedef struct packed {
    logic [21:0]        up;
    logic [21:0]        down;
    logic [21:0]        center;
    logic [21:0]        outer;
    logic [37:0]        e2;
    logic signed [34:0] wx;
    logic signed [34:0] wy;
    logic [45:0]        wx2;
    logic [45:0]        wy2;
    logic               empty;
  } ccm_rec_t;

  // Finished result word
  typedef struct packed {
    logic [21:0]        outer;
    logic [21:0]        center;
    logic [21:0]        down;
    logic [21:0]        up;
    logic [12:0]        sy;
    logic [12:0]        sx;
    logic signed [15:0] bal;
    logic signed [12:0] cy;
    logic signed [12:0] cx;
    logic               empty;
    logic               valid;
  } ccm_res_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_CHECK,
    DIV_RUN
  } div_state_e;

  typedef enum logic [4:0] {
    BK_IDLE,
    BK_LOAD,
    BK_CX,
    BK_CX_WAIT,
    BK_CY,
    BK_CY_WAIT,
    BK_BAL,
    BK_BAL_WAIT,
    BK_SS,
    BK_SS_WAIT,
    BK_AM,
    BK_AM_WAIT,
    BK_BM,
    BK_BM_WAIT,
    BK_DIV,
    BK_DIV_WAIT,
    BK_SQRT,
    BK_DONE
  } back_state_e;

endpackage

@@ sv/ccm_fifo.sv @@
// Short queue of closed clusters between front and back.
// Depends on ccm_pkg for the record type and the depth.
module ccm_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ccm_pkg::ccm_rec_t wdata_i,
  input  logic              pop_i,
  output logic              valid_o,
  output ccm_pkg::ccm_rec_t rdata_o,
  output logic [ccm_pkg::QCountW-1:0] count_o
);

  localparam int unsigned PtrW = $clog2(ccm_pkg::QueueDepth);

  ccm_pkg::ccm_rec_t mem_q [ccm_pkg::QueueDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [ccm_pkg::QCountW-1:0] cnt_q;

  // Store pushed words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + ccm_pkg::QCountW'(push_i) - ccm_pkg::QCountW'(pop_i);
    end
  end

  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rp_q];
  assign count_o = cnt_q;

endmodule

@@ sv/ccm_front.sv @@
// Front end: classifies hits and accumulates the cluster sums.
// Depends on ccm_pkg; feeds closed clusters into ccm_fifo.
module ccm_front #(
  parameter int unsigned MaxHits = ccm_pkg::MaxHitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               hit_valid_i,
  output logic               hit_ready_o,
  input  logic [15:0]        hit_energy_i,
  input  logic signed [12:0] hit_x_i,
  input  logic signed [12:0] hit_y_i,
  input  logic               downstream_i,
  input  logic               last_hit_i,
  input  logic [15:0]        threshold_i,
  input  logic [11:0]        half_width_i,
  input  logic [ccm_pkg::QCountW-1:0] q_count_i,
  output logic               push_o,
  output ccm_pkg::ccm_rec_t  rec_o
);

  localparam int unsigned HitCntW = $clog2(MaxHits + 1);
  localparam int unsigned OccW    = ccm_pkg::QCountW + 1;

  logic [HitCntW-1:0] cnt_q, cnt_d;
  logic acc, take0, empty0, central0;
  logic [12:0] ax0, ay0;
  logic [OccW-1:0] occ;

  // Stage flags: valid, last, taken, downstream, central, empty
  logic v1_q, l1_q, t1_q, d1_q, c1_q, m1_q;
  logic v2_q, l2_q, t2_q, d2_q, c2_q, m2_q;
  logic v3_q, l3_q, t3_q, d3_q, c3_q, m3_q;

  logic [15:0] e1_q, e2_q, e3_q;
  logic signed [12:0] x1_q, y1_q;
  logic [12:0] ax1_q, ay1_q;
  logic [31:0] pee2_q, pee3_q;
  logic signed [29:0] pex2_q, pey2_q, pex3_q, pey3_q;
  logic [25:0] axsq2_q, aysq2_q;
  logic [40:0] pxx3_q, pyy3_q;

  ccm_pkg::ccm_rec_t sum_q, sum_n;
  logic [22:0] up_s, dn_s, ce_s, ou_s;
  logic [38:0] e2_s;
  logic signed [35:0] wx_s, wy_s;
  logic [46:0] x2_s, y2_s;

  // Hold off new hits while every queue slot may be claimed
  assign occ = OccW'(q_count_i) + OccW'(v1_q && l1_q) + OccW'(v2_q && l2_q)
             + OccW'(v3_q && l3_q);
  assign hit_ready_o = (occ < OccW'(ccm_pkg::QueueDepth));
  assign acc = hit_valid_i && hit_ready_o;

  // Classify the incoming word
  assign ax0 = hit_x_i[12] ? 13'(-hit_x_i) : 13'(hit_x_i);
  assign ay0 = hit_y_i[12] ? 13'(-hit_y_i) : 13'(hit_y_i);
  assign take0 = (hit_energy_i >= threshold_i) && (cnt_q < HitCntW'(MaxHits));
  assign empty0 = (cnt_q == '0) && !take0;
  assign central0 = (ax0 < 13'(half_width_i)) && (ay0 < 13'(half_width_i));

  always_comb begin
    cnt_d = cnt_q;
    if (acc) begin
      cnt_d = last_hit_i ? '0 : cnt_q + HitCntW'(take0);
    end
  end

  // Stage valid and flag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
      l1_q <= 1'b0; l2_q <= 1'b0; l3_q <= 1'b0;
      t1_q <= 1'b0; t2_q <= 1'b0; t3_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      v1_q <= acc;  l1_q <= acc && last_hit_i; t1_q <= acc && take0;
      v2_q <= v1_q; l2_q <= l1_q;              t2_q <= t1_q;
      v3_q <= v2_q; l3_q <= l2_q;              t3_q <= t2_q;
    end
  end

  // Payload pipeline: products, then energy times squared coordinate
  always_ff @(posedge clk_i) begin
    d1_q <= downstream_i; c1_q <= central0; m1_q <= empty0;
    e1_q <= hit_energy_i; x1_q <= hit_x_i; y1_q <= hit_y_i;
    ax1_q <= ax0; ay1_q <= ay0;

    d2_q <= d1_q; c2_q <= c1_q; m2_q <= m1_q;
    e2_q <= e1_q;
    pee2_q <= e1_q * e1_q;
    pex2_q <= $signed({1'b0, e1_q}) * x1_q;
    pey2_q <= $signed({1'b0, e1_q}) * y1_q;
    axsq2_q <= 26'(ax1_q) * 26'(ax1_q);
    aysq2_q <= 26'(ay1_q) * 26'(ay1_q);

    d3_q <= d2_q; c3_q <= c2_q; m3_q <= m2_q;
    e3_q <= e2_q; pee3_q <= pee2_q; pex3_q <= pex2_q; pey3_q <= pey2_q;
    pxx3_q <= 41'(e2_q) * 41'(axsq2_q);
    pyy3_q <= 41'(e2_q) * 41'(aysq2_q);
  end

  // Saturating accumulation
  always_comb begin
    up_s = {1'b0, sum_q.up} + 23'(e3_q);
    dn_s = {1'b0, sum_q.down} + 23'(e3_q);
    ce_s = {1'b0, sum_q.center} + 23'(e3_q);
    ou_s = {1'b0, sum_q.outer} + 23'(e3_q);
    e2_s = {1'b0, sum_q.e2} + 39'(pee3_q);
    wx_s = 36'(sum_q.wx) + 36'(pex3_q);
    wy_s = 36'(sum_q.wy) + 36'(pey3_q);
    x2_s = {1'b0, sum_q.wx2} + 47'(pxx3_q);
    y2_s = {1'b0, sum_q.wy2} + 47'(pyy3_q);
    sum_n = sum_q;
    sum_n.empty = m3_q;
    if (v3_q && t3_q) begin
      if (d3_q) begin
        sum_n.down = dn_s[22] ? '1 : dn_s[21:0];
      end else begin
        sum_n.up = up_s[22] ? '1 : up_s[21:0];
      end
      if (c3_q) begin
        sum_n.center = ce_s[22] ? '1 : ce_s[21:0];
      end else begin
        sum_n.outer = ou_s[22] ? '1 : ou_s[21:0];
      end
      sum_n.e2 = e2_s[38] ? '1 : e2_s[37:0];
      if (wx_s[35] != wx_s[34]) begin
        sum_n.wx = wx_s[35] ? {1'b1, 34'd0} : {1'b0, {34{1'b1}}};
      end else begin
        sum_n.wx = wx_s[34:0];
      end
      if (wy_s[35] != wy_s[34]) begin
        sum_n.wy = wy_s[35] ? {1'b1, 34'd0} : {1'b0, {34{1'b1}}};
      end else begin
        sum_n.wy = wy_s[34:0];
      end
      sum_n.wx2 = x2_s[46] ? '1 : x2_s[45:0];
      sum_n.wy2 = y2_s[46] ? '1 : y2_s[45:0];
    end
  end

  // Clear sums after the closing hit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (v3_q && l3_q) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_n;
    end
  end

  assign push_o = v3_q && l3_q;
  assign rec_o  = sum_n;

endmodule

@@ sv/ccm_mul.sv @@
// Multi-cycle multiplier: four 24x24 partial products, one per cycle.
// Depends on ccm_pkg for widths; used by ccm_back.
module ccm_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ccm_pkg::MulW-1:0]  a_i,
  input  logic [ccm_pkg::MulW-1:0]  b_i,
  output logic                      done_o,
  output logic [ccm_pkg::ProdW-1:0] p_o
);

  localparam int unsigned HW = ccm_pkg::HalfW;
  localparam int unsigned PW = ccm_pkg::ProdW;

  logic [ccm_pkg::MulW-1:0] a_q, b_q;
  logic [HW-1:0] pa, pb;
  logic [2*HW-1:0] pp_q;
  logic [1:0] sh_q, sh;
  logic [2:0] idx_q;
  logic busy_q, ppv_q, done_q;
  logic [PW-1:0] acc_q, pp_ext;

  // Pick the partial product of this step
  always_comb begin
    pa = a_q[HW-1:0];
    pb = b_q[HW-1:0];
    sh = 2'd0;
    unique case (idx_q[1:0])
      2'd0: begin
        pa = a_q[HW-1:0]; pb = b_q[HW-1:0]; sh = 2'd0;
      end
      2'd1: begin
        pa = a_q[2*HW-1:HW]; pb = b_q[HW-1:0]; sh = 2'd1;
      end
      2'd2: begin
        pa = a_q[HW-1:0]; pb = b_q[2*HW-1:HW]; sh = 2'd1;
      end
      default: begin
        pa = a_q[2*HW-1:HW]; pb = b_q[2*HW-1:HW]; sh = 2'd2;
      end
    endcase
  end

  always_comb begin
    unique case (sh_q)
      2'd0:    pp_ext = PW'(pp_q);
      2'd1:    pp_ext = PW'(pp_q) << HW;
      default: pp_ext = PW'(pp_q) << (2 * HW);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    pp_q <= pa * pb;
    sh_q <= sh;
  end

  // Step through the products and add them up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ppv_q  <= 1'b0;
      idx_q  <= '0;
      done_q <= 1'b0;
      acc_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        ppv_q  <= 1'b0;
        idx_q  <= '0;
        acc_q  <= '0;
      end else if (busy_q) begin
        ppv_q <= !idx_q[2];
        if (!idx_q[2]) idx_q <= idx_q + 1'b1;
        if (ppv_q) acc_q <= acc_q + pp_ext;
        if (idx_q[2] && ppv_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

@@ sv/ccm_div.sv @@
// Restoring divider, one quotient bit per cycle, with an overflow check.
// Depends on ccm_pkg; used by ccm_back.
module ccm_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [ccm_pkg::NumW-1:0] num_i,
  input  logic [ccm_pkg::DenW-1:0] den_i,
  input  logic [4:0]               qbits_i,
  output logic                     done_o,
  output logic                     ovf_o,
  output logic [ccm_pkg::QuoW-1:0] q_o
);

  ccm_pkg::div_state_e st_q, st_d;
  logic [ccm_pkg::NumW-1:0] rem_q, rem_d, dsh_q, dsh_d, t;
  logic [ccm_pkg::QuoW-1:0] quo_q, quo_d;
  logic [4:0] cnt_q, cnt_d;
  logic ovf_q, ovf_d, done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ccm_pkg::DIV_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
    ovf_q <= ovf_d;
  end

  // Load, check the quotient range, then shift out one bit a cycle
  always_comb begin
    st_d   = st_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    done_d = 1'b0;
    t      = dsh_q >> 1;
    unique case (st_q)
      ccm_pkg::DIV_IDLE: begin
        if (start_i) begin
          rem_d = num_i;
          dsh_d = ccm_pkg::NumW'(den_i) << qbits_i;
          cnt_d = qbits_i;
          quo_d = '0;
          ovf_d = 1'b0;
          st_d  = ccm_pkg::DIV_CHECK;
        end
      end
      ccm_pkg::DIV_CHECK: begin
        if (rem_q >= dsh_q) begin
          ovf_d  = 1'b1;
          done_d = 1'b1;
          st_d   = ccm_pkg::DIV_IDLE;
        end else begin
          st_d = ccm_pkg::DIV_RUN;
        end
      end
      ccm_pkg::DIV_RUN: begin
        if (rem_q >= t) begin
          rem_d = rem_q - t;
          quo_d = {quo_q[ccm_pkg::QuoW-2:0], 1'b1};
        end else begin
          quo_d = {quo_q[ccm_pkg::QuoW-2:0], 1'b0};
        end
        dsh_d = t;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == 5'd1) begin
          done_d = 1'b1;
          st_d   = ccm_pkg::DIV_IDLE;
        end
      end
      default: st_d = ccm_pkg::DIV_IDLE;
    endcase
  end

  assign done_o = done_q;
  assign ovf_o  = ovf_q;
  assign q_o    = quo_q;

endmodule

@@ sv/ccm_back.sv @@
// Back end: centroid, side balance and spread of one closed cluster.
// Depends on ccm_pkg, ccm_mul and ccm_div; holds the output register.
module ccm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  ccm_pkg::ccm_rec_t q_rec_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ccm_pkg::ccm_res_t out_res_o
);

  ccm_pkg::back_state_e st_q, st_d;
  ccm_pkg::ccm_rec_t rec_q, rec_d;
  ccm_pkg::ccm_res_t res_q, res_d;
  logic ov_q, ov_d;

  logic [22:0] s_q, s_d;
  logic signed [12:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [15:0] bal_q, bal_d;
  logic [12:0] sx_q, sx_d, sy_q, sy_d;
  logic sv_q, sv_d, axis_q, axis_d;
  logic [ccm_pkg::DenW-1:0] den_q, den_d;
  logic [69:0] a_q, a_d;
  logic [ccm_pkg::QuoW-1:0] q_q, q_d;
  logic [12:0] root_q, root_d, t;
  logic [3:0] bit_q, bit_d;
  logic [25:0] tt;

  logic [34:0] wx_mag, wy_mag, lin_mag;
  logic [45:0] sq_sum;
  logic [22:0] d_mag;
  logic d_neg;

  logic mul_start, mul_done;
  logic [ccm_pkg::MulW-1:0] mul_a, mul_b;
  logic [ccm_pkg::ProdW-1:0] mul_p;
  logic div_start, div_done, div_ovf;
  logic [ccm_pkg::NumW-1:0] div_num;
  logic [ccm_pkg::DenW-1:0] div_den;
  logic [4:0] div_qb;
  logic [ccm_pkg::QuoW-1:0] div_q;

  // Round a centroid quotient back to a clamped signed coordinate
  function automatic logic [12:0] clamp13(logic neg, logic ovf,
                                          logic [ccm_pkg::QuoW-1:0] q);
    logic [12:0] r;
    if (!neg) begin
      r = (ovf || q > 26'd4095) ? 13'd4095 : q[12:0];
    end else begin
      r = (ovf || q > 26'd4096) ? 13'h1000 : 13'(13'd0 - q[12:0]);
    end
    return r;
  endfunction

  ccm_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  ccm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .qbits_i (div_qb),
    .done_o  (div_done),
    .ovf_o   (div_ovf),
    .q_o     (div_q)
  );

  // Magnitudes of the signed sums
  assign wx_mag  = rec_q.wx[34] ? 35'(-rec_q.wx) : 35'(rec_q.wx);
  assign wy_mag  = rec_q.wy[34] ? 35'(-rec_q.wy) : 35'(rec_q.wy);
  assign lin_mag = axis_q ? wy_mag : wx_mag;
  assign sq_sum  = axis_q ? rec_q.wy2 : rec_q.wx2;
  assign d_neg   = (rec_q.down < rec_q.up);
  assign d_mag   = d_neg ? 23'(rec_q.up - rec_q.down) : 23'(rec_q.down - rec_q.up);

  // Square root trial value
  assign t  = root_q | (13'd1 << bit_q);
  assign tt = 26'(t) * 26'(t);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ccm_pkg::BK_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q  <= rec_d;
    res_q  <= res_d;
    s_q    <= s_d;
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    bal_q  <= bal_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    sv_q   <= sv_d;
    axis_q <= axis_d;
    den_q  <= den_d;
    a_q    <= a_d;
    q_q    <= q_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  // Sequence the arithmetic of one cluster
  always_comb begin
    st_d = st_q;  rec_d = rec_q; res_d = res_q;
    s_d = s_q;    cx_d = cx_q;   cy_d = cy_q;   bal_d = bal_q;
    sx_d = sx_q;  sy_d = sy_q;   sv_d = sv_q;   axis_d = axis_q;
    den_d = den_q; a_d = a_q;    q_d = q_q;
    root_d = root_q; bit_d = bit_q;
    ov_d = ov_q && !out_ready_i;
    q_pop_o   = 1'b0;
    mul_start = 1'b0;
    mul_a     = ccm_pkg::MulW'(sq_sum);
    mul_b     = ccm_pkg::MulW'(s_q);
    div_start = 1'b0;
    div_num   = ccm_pkg::NumW'({wx_mag, 1'b0}) + ccm_pkg::NumW'(s_q);
    div_den   = ccm_pkg::DenW'({s_q, 1'b0});
    div_qb    = ccm_pkg::QCentroid;
    unique case (st_q)
      ccm_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          rec_d   = q_rec_i;
          st_d    = ccm_pkg::BK_LOAD;
        end
      end
      ccm_pkg::BK_LOAD: begin
        s_d = {1'b0, rec_q.up} + {1'b0, rec_q.down};
        cx_d = '0; cy_d = '0; bal_d = '0; sx_d = '0; sy_d = '0;
        sv_d = 1'b0; axis_d = 1'b0;
        st_d = (s_d == '0) ? ccm_pkg::BK_DONE : ccm_pkg::BK_CX;
      end
      ccm_pkg::BK_CX: begin
        div_start = 1'b1;
        st_d = ccm_pkg::BK_CX_WAIT;
      end
      ccm_pkg::BK_CX_WAIT: begin
        if (div_done) begin
          cx_d = clamp13(rec_q.wx[34], div_ovf, div_q);
          st_d = ccm_pkg::BK_CY;
        end
      end
      ccm_pkg::BK_CY: begin
        div_num   = ccm_pkg::NumW'({wy_mag, 1'b0}) + ccm_pkg::NumW'(s_q);
        div_start = 1'b1;
        st_d = ccm_pkg::BK_CY_WAIT;
      end
      ccm_pkg::BK_CY_WAIT: begin
        if (div_done) begin
          cy_d = clamp13(rec_q.wy[34], div_ovf, div_q);
          st_d = ccm_pkg::BK_BAL;
        end
      end
      ccm_pkg::BK_BAL: begin
        div_num   = ccm_pkg::NumW'({d_mag, 16'd0}) + ccm_pkg::NumW'(s_q);
        div_qb    = ccm_pkg::QBalance;
        div_start = 1'b1;
        st_d = ccm_pkg::BK_BAL_WAIT;
      end
      ccm_pkg::BK_BAL_WAIT: begin
        if (div_done) begin
          if (!d_neg) begin
            bal_d = (div_q > 26'd32767) ? 16'sd32767 : $signed(div_q[15:0]);
          end else begin
            bal_d = $signed(16'(16'd0 - div_q[15:0]));
          end
          st_d = ccm_pkg::BK_SS;
        end
      end
      ccm_pkg::BK_SS: begin
        mul_a     = ccm_pkg::MulW'(s_q);
        mul_start = 1'b1;
        st_d = ccm_pkg::BK_SS_WAIT;
      end
      ccm_pkg::BK_SS_WAIT: begin
        if (mul_done) begin
          if (mul_p[45:0] > 46'(rec_q.e2)) begin
            den_d = mul_p[45:0] - 46'(rec_q.e2);
            st_d  = ccm_pkg::BK_AM;
          end else begin
            st_d = ccm_pkg::BK_DONE;
          end
        end
      end
      ccm_pkg::BK_AM: begin
        mul_start = 1'b1;
        st_d = ccm_pkg::BK_AM_WAIT;
      end
      ccm_pkg::BK_AM_WAIT: begin
        if (mul_done) begin
          a_d  = mul_p[69:0];
          st_d = ccm_pkg::BK_BM;
        end
      end
      ccm_pkg::BK_BM: begin
        mul_a     = ccm_pkg::MulW'(lin_mag);
        mul_b     = ccm_pkg::MulW'(lin_mag);
        mul_start = 1'b1;
        st_d = ccm_pkg::BK_BM_WAIT;
      end
      ccm_pkg::BK_BM_WAIT: begin
        if (mul_done) begin
          if (70'(a_q) < mul_p[69:0]) begin
            // Negative variance on this axis: both spreads drop to zero
            sx_d = '0;
            sy_d = '0;
            st_d = ccm_pkg::BK_DONE;
          end else begin
            a_d  = a_q - mul_p[69:0];
            st_d = ccm_pkg::BK_DIV;
          end
        end
      end
      ccm_pkg::BK_DIV: begin
        div_num   = ccm_pkg::NumW'(a_q);
        div_den   = den_q;
        div_qb    = ccm_pkg::QSpread;
        div_start = 1'b1;
        st_d = ccm_pkg::BK_DIV_WAIT;
      end
      ccm_pkg::BK_DIV_WAIT: begin
        if (div_done) begin
          if (div_ovf) begin
            if (!axis_q) begin
              sx_d = 13'h1FFF; axis_d = 1'b1; st_d = ccm_pkg::BK_AM;
            end else begin
              sy_d = 13'h1FFF; sv_d = 1'b1; st_d = ccm_pkg::BK_DONE;
            end
          end else begin
            q_d    = div_q;
            root_d = '0;
            bit_d  = 4'd12;
            st_d   = ccm_pkg::BK_SQRT;
          end
        end
      end
      ccm_pkg::BK_SQRT: begin
        if (tt <= q_q) root_d = t;
        if (bit_q == 4'd0) begin
          if (!axis_q) begin
            sx_d = root_d; axis_d = 1'b1; st_d = ccm_pkg::BK_AM;
          end else begin
            sy_d = root_d; sv_d = 1'b1; st_d = ccm_pkg::BK_DONE;
          end
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end
      ccm_pkg::BK_DONE: begin
        // Hand the word to the output register once it is free
        if (!ov_q || out_ready_i) begin
          res_d.cx     = cx_q;
          res_d.cy     = cy_q;
          res_d.bal    = bal_q;
          res_d.sx     = sx_q;
          res_d.sy     = sy_q;
          res_d.up     = rec_q.up;
          res_d.down   = rec_q.down;
          res_d.center = rec_q.center;
          res_d.outer  = rec_q.outer;
          res_d.valid  = sv_q;
          res_d.empty  = rec_q.empty;
          ov_d = 1'b1;
          st_d = ccm_pkg::BK_IDLE;
        end
      end
      default: st_d = ccm_pkg::BK_IDLE;
    endcase
  end

  assign out_valid_o = ov_q;
  assign out_res_o   = res_q;

endmodule

@@ sv/calorimeter_cluster_moments_top.sv @@
// Top level of the cluster moments block: ports, configuration registers.
// Depends on ccm_pkg, ccm_front, ccm_fifo and ccm_back.
//
//   channel   direction  handshake                    word
//   s_axis    in         s_axis_tvalid/s_axis_tready  one hit, tlast closes cluster
//   m_axis    out        m_axis_tvalid/m_axis_tready  one cluster result
//   cfg       in         cfg_valid_i/cfg_ready_o      register index and value
//
// Hits are taken one per clock while the queue has room. The back end works
// one cluster at a time with its shared divider (one quotient bit a cycle)
// and the 13-step square root. Up to four closed clusters wait in the queue;
// hits stall when those and the closing hits in the front pipeline would
// fill it. The output register lets the back end start the next cluster
// while a result waits. Reset clears all sums; no clearing pass is needed.
module calorimeter_cluster_moments_top #(
  parameter int unsigned MaxHits = ccm_pkg::MaxHitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [15:0] hit_energy, [28:16] hit_x, [41:29] hit_y, [47:42] zero
  input  logic [47:0]  s_axis_tdata,
  // [0] downstream
  input  logic         s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [12:0] centroid_x, [25:13] centroid_y, [41:26] side_balance,
  // [54:42] spread_x, [67:55] spread_y, [89:68] energy_up,
  // [111:90] energy_down, [133:112] energy_center, [155:134] energy_outer,
  // [159:156] zero
  output logic [159:0] m_axis_tdata,
  // [0] spread_valid, [1] cluster_empty
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_addr_i,
  input  logic [15:0]  cfg_data_i
);

  logic [15:0] thr_q;
  logic [11:0] hw_q;
  logic push, pop, q_valid;
  ccm_pkg::ccm_rec_t push_rec, q_rec;
  logic [ccm_pkg::QCountW-1:0] q_count;
  ccm_pkg::ccm_res_t res;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
      hw_q  <= ccm_pkg::HalfWidthRst;
    end else if (cfg_valid_i) begin
      unique case (ccm_pkg::cfg_idx_e'(cfg_addr_i))
        ccm_pkg::CFG_THRESHOLD:  thr_q <= cfg_data_i;
        ccm_pkg::CFG_HALF_WIDTH: hw_q  <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  ccm_front #(
    .MaxHits (MaxHits)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hit_valid_i  (s_axis_tvalid),
    .hit_ready_o  (s_axis_tready),
    .hit_energy_i (s_axis_tdata[15:0]),
    .hit_x_i      ($signed(s_axis_tdata[28:16])),
    .hit_y_i      ($signed(s_axis_tdata[41:29])),
    .downstream_i (s_axis_tuser),
    .last_hit_i   (s_axis_tlast),
    .threshold_i  (thr_q),
    .half_width_i (hw_q),
    .q_count_i    (q_count),
    .push_o       (push),
    .rec_o        (push_rec)
  );

  ccm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_rec),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (q_rec),
    .count_o (q_count)
  );

  ccm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_rec_i     (q_rec),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  // Pack the result word
  assign m_axis_tdata = {4'd0, res.outer, res.center, res.down, res.up,
                         res.sy, res.sx, res.bal, res.cy, res.cx};
  assign m_axis_tuser = {res.empty, res.valid};

endmodule

@@ tb/tb_calorimeter_cluster_moments_top.sv @@
// Self-checking testbench for calorimeter_cluster_moments_top: streams hit
// clusters with random idling on both sides and checks every cluster result
// against an in-bench predictor or typed-in results; needs ccm_pkg and RTL.
module tb_calorimeter_cluster_moments_top;

  localparam int unsigned HitLimit = ccm_pkg::MaxHitsDef;

  // Expected cluster result, fields at the block's widths
  typedef struct {
    logic [12:0] cx;
    logic [12:0] cy;
    logic [15:0] bal;
    logic [12:0] sx;
    logic [12:0] sy;
    logic [21:0] up;
    logic [21:0] down;
    logic [21:0] center;
    logic [21:0] outer;
    logic        valid;
    logic        empty;
  } moments_t;

  // One directed hit; known marks a result typed in by hand
  typedef struct {
    logic [15:0] e;
    logic [12:0] x;
    logic [12:0] y;
    logic        down;
    logic        last;
    bit          known;
    moments_t    res;
  } hit_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic         cfg_addr_i = 1'b0;
  logic [15:0]  cfg_data_i = '0;

  calorimeter_cluster_moments_top dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_addr_i, .cfg_data_i
  );

  always #6 clk_i = ~clk_i;

  // Predictor state and configuration
  logic [15:0]        thr_q;
  logic [11:0]        half_w_q;
  longint unsigned    acc_up, acc_down, acc_center, acc_outer, acc_e2;
  longint             acc_wx, acc_wy;
  longint unsigned    acc_wx2, acc_wy2;
  int unsigned        hit_cnt;

  moments_t    moments_q[$];
  int unsigned errors = 0;
  int unsigned hits_sent = 0;
  int unsigned clusters_seen = 0;
  int unsigned invalid_seen = 0;
  bit          burst = 1'b0;

  task automatic report(input string field, input longint got, input longint want);
    $display("MISMATCH %0s: got %0h expected %0h (cluster %0d)", field, got, want,
             clusters_seen);
    errors++;
  endtask

  function automatic longint unsigned sat_u(input longint unsigned v,
                                            input int unsigned w);
    longint unsigned lim;
    lim = (64'd1 << w) - 1;
    return v > lim ? lim : v;
  endfunction

  function automatic longint sat_s35(input longint v);
    longint hi, lo;
    hi = (64'sd1 <<< 34) - 1;
    lo = -(64'sd1 <<< 34);
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint round_q(input longint n, input longint unsigned d);
    longint unsigned mag, q;
    mag = n < 0 ? -n : n;
    q = (2 * mag + d) / (2 * d);
    return n < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // Corrected rms on one axis; returns 0 when the numerator is negative
  function automatic bit axis_spread(input longint unsigned sq, input longint lin,
                                     input longint unsigned s, input longint unsigned den,
                                     output logic [12:0] rms);
    logic [127:0] a, b, num, q, r, t;
    longint unsigned mag;
    mag = lin < 0 ? -lin : lin;
    a = 128'(sq) * 128'(s);
    b = 128'(mag) * 128'(mag);
    rms = '0;
    if (a < b) return 1'b0;
    num = a - b;
    if (num >= (128'(den) << 26)) begin
      rms = 13'h1fff;
      return 1'b1;
    end
    q = num / 128'(den);
    r = '0;
    for (int i = 12; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t <= q) r = t;
    end
    rms = r[12:0];
    return 1'b1;
  endfunction

  task automatic clear_sums();
    acc_up = 0; acc_down = 0; acc_center = 0; acc_outer = 0; acc_e2 = 0;
    acc_wx = 0; acc_wy = 0; acc_wx2 = 0; acc_wy2 = 0; hit_cnt = 0;
  endtask

  // Accumulate one accepted hit; on the last hit build the cluster result
  task automatic predict_hit(input logic [15:0] e, input logic [12:0] xr,
                             input logic [12:0] yr, input logic down, input logic last,
                             output bit done, output moments_t m);
    longint x, y, s, cx, cy, bal;
    longint unsigned ax, ay, ee, den;
    logic [12:0] sx, sy;
    bit okx, oky;
    x = longint'($signed(xr));
    y = longint'($signed(yr));
    ee = e;
    done = 1'b0;
    m = '{default: '0};
    if (e >= thr_q && hit_cnt < HitLimit) begin
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      hit_cnt++;
      if (down) acc_down = sat_u(acc_down + ee, 22);
      else acc_up = sat_u(acc_up + ee, 22);
      if (ax < half_w_q && ay < half_w_q) acc_center = sat_u(acc_center + ee, 22);
      else acc_outer = sat_u(acc_outer + ee, 22);
      acc_e2 = sat_u(acc_e2 + ee * ee, 38);
      acc_wx = sat_s35(acc_wx + longint'(ee) * x);
      acc_wy = sat_s35(acc_wy + longint'(ee) * y);
      acc_wx2 = sat_u(acc_wx2 + ee * ax * ax, 46);
      acc_wy2 = sat_u(acc_wy2 + ee * ay * ay, 46);
    end
    if (!last) return;
    done = 1'b1;
    s = acc_up + acc_down;
    if (s != 0) begin
      cx = clamp(round_q(acc_wx, s), -4096, 4095);
      cy = clamp(round_q(acc_wy, s), -4096, 4095);
      bal = clamp(round_q((longint'(acc_down) - longint'(acc_up)) * 32768, s),
                  -32768, 32767);
      m.cx = cx[12:0];
      m.cy = cy[12:0];
      m.bal = bal[15:0];
      if (s * s > acc_e2) begin
        den = s * s - acc_e2;
        okx = axis_spread(acc_wx2, acc_wx, s, den, sx);
        oky = axis_spread(acc_wy2, acc_wy, s, den, sy);
        if (okx && oky) begin
          m.sx = sx;
          m.sy = sy;
          m.valid = 1'b1;
        end
      end
    end
    m.up = acc_up[21:0];
    m.down = acc_down[21:0];
    m.center = acc_center[21:0];
    m.outer = acc_outer[21:0];
    m.empty = hit_cnt == 0;
    clear_sums();
  endtask

  // Send one hit word; the expected result is queued at acceptance
  task automatic send_hit(input logic [15:0] e, input logic [12:0] x, input logic [12:0] y,
                          input logic down, input logic last, input bit known,
                          input moments_t typed);
    int unsigned gap;
    bit done;
    moments_t m;
    gap = burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, y, x, e};
    s_axis_tuser <= down;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    hits_sent++;
    predict_hit(e, x, y, down, last, done, m);
    if (done) moments_q.push_back(known ? typed : m);
  endtask

  // Wait for every result, then let the back end drain before a write
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (moments_q.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  // Write one register, then drop valid again
  task automatic write_reg(input ccm_pkg::cfg_idx_e idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (idx == ccm_pkg::CFG_THRESHOLD) thr_q = val;
    else half_w_q = val[11:0];
  endtask

  // Random cluster: mostly short, now and then past the hit limit
  task automatic random_cluster();
    int unsigned len;
    logic [12:0] x, y;
    logic [15:0] e;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 8);
    burst = $urandom_range(0, 3) == 0;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 3))
        0: e = 16'($urandom);
        1: e = 16'($urandom_range(0, 255));
        2: e = 16'(thr_q + $urandom_range(0, 3));
        default: e = 16'($urandom_range(0, 4000));
      endcase
      if ($urandom_range(0, 1)) begin
        x = 13'($urandom); y = 13'($urandom);
      end else begin
        x = 13'($signed($urandom_range(0, 600)) - 300);
        y = 13'($signed($urandom_range(0, 600)) - 300);
      end
      send_hit(e, x, y, 1'($urandom_range(0, 1)), i == len - 1, 1'b0, '{default: '0});
    end
    burst = 1'b0;
  endtask

  // Result side: random stalls, then compare against the oldest expectation
  initial begin
    int unsigned gap;
    moments_t w;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      clusters_seen++;
      if (m_axis_tuser[0] == 1'b0) invalid_seen++;
      if (moments_q.size() == 0) begin
        report("unexpected result word", 1, 0);
      end else begin
        w = moments_q.pop_front();
        if (m_axis_tdata[12:0] != w.cx) report("centroid_x", m_axis_tdata[12:0], w.cx);
        if (m_axis_tdata[25:13] != w.cy) report("centroid_y", m_axis_tdata[25:13], w.cy);
        if (m_axis_tdata[41:26] != w.bal)
          report("side_balance", m_axis_tdata[41:26], w.bal);
        if (m_axis_tdata[54:42] != w.sx) report("spread_x", m_axis_tdata[54:42], w.sx);
        if (m_axis_tdata[67:55] != w.sy) report("spread_y", m_axis_tdata[67:55], w.sy);
        if (m_axis_tdata[89:68] != w.up) report("energy_up", m_axis_tdata[89:68], w.up);
        if (m_axis_tdata[111:90] != w.down)
          report("energy_down", m_axis_tdata[111:90], w.down);
        if (m_axis_tdata[133:112] != w.center)
          report("energy_center", m_axis_tdata[133:112], w.center);
        if (m_axis_tdata[155:134] != w.outer)
          report("energy_outer", m_axis_tdata[155:134], w.outer);
        if (m_axis_tuser[0] != w.valid) report("spread_valid", m_axis_tuser[0], w.valid);
        if (m_axis_tuser[1] != w.empty) report("cluster_empty", m_axis_tuser[1], w.empty);
      end
    end
  end

  // Hard stop in case the block hangs
  initial begin
    #(12 * 3000000);
    $display("Test completed with failures");
    $finish;
  end

  // Stimulus
  initial begin
    hit_row_t rows[$];
    moments_t z;
    z = '{default: '0};
    thr_q = '0;
    half_w_q = ccm_pkg::HalfWidthRst;
    clear_sums();
    // single zero-energy hit: nothing is defined, but the cluster is not empty
    rows.push_back('{16'd0, 13'd0, 13'd0, 1'b0, 1'b1, 1'b1, z});
    // single hit: one effective hit gives no spread, balance clamps high
    rows.push_back('{16'd100, 13'd16, -13'sd32, 1'b1, 1'b1, 1'b1,
                     '{13'd16, -13'sd32, 16'h7fff, 13'd0, 13'd0, 22'd0, 22'd100,
                       22'd100, 22'd0, 1'b0, 1'b0}});
    // extreme single hit at the corner, upstream
    rows.push_back('{16'hffff, 13'h1000, 13'h0fff, 1'b0, 1'b1, 1'b1,
                     '{13'h1000, 13'h0fff, 16'h8000, 13'd0, 13'd0, 22'd65535, 22'd0,
                       22'd0, 22'd65535, 1'b0, 1'b0}});
    // two symmetric hits, then an edge of the central square
    rows.push_back('{16'd500, 13'd100, 13'd100, 1'b0, 1'b0, 1'b0, z});
    rows.push_back('{16'd500, -13'sd100, -13'sd100, 1'b1, 1'b1, 1'b0, z});
    rows.push_back('{16'd7, 13'd223, -13'sd223, 1'b1, 1'b0, 1'b0, z});
    rows.push_back('{16'd9, 13'd224, 13'd0, 1'b0, 1'b0, 1'b0, z});
    rows.push_back('{16'd3, -13'sd224, 13'd5, 1'b1, 1'b1, 1'b0, z});
    // rounding ties and a wide spread
    rows.push_back('{16'd1, 13'd1, 13'd0, 1'b0, 1'b0, 1'b0, z});
    rows.push_back('{16'd1, 13'd0, -13'sd1, 1'b1, 1'b1, 1'b0, z});
    rows.push_back('{16'hffff, 13'h0fff, 13'h1000, 1'b1, 1'b0, 1'b0, z});
    rows.push_back('{16'hffff, 13'h1000, 13'h0fff, 1'b0, 1'b0, 1'b0, z});
    rows.push_back('{16'hfffe, 13'h0fff, 13'h0fff, 1'b1, 1'b1, 1'b0, z});
    // mixed cluster with a zero-energy hit inside
    rows.push_back('{16'd1200, 13'd40, 13'd55, 1'b0, 1'b0, 1'b0, z});
    rows.push_back('{16'd0, 13'd999, -13'sd999, 1'b1, 1'b0, 1'b0, z});
    rows.push_back('{16'd3300, -13'sd70, 13'd12, 1'b1, 1'b1, 1'b0, z});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i])
      send_hit(rows[i].e, rows[i].x, rows[i].y, rows[i].down, rows[i].last,
               rows[i].known, rows[i].res);
    wait_idle();

    // top threshold: a hit below it leaves the cluster empty
    write_reg(ccm_pkg::CFG_THRESHOLD, 16'hffff);
    write_reg(ccm_pkg::CFG_HALF_WIDTH, 16'd0);
    z.empty = 1'b1;
    send_hit(16'd1, 13'd5, 13'd5, 1'b1, 1'b1, 1'b1, z);
    send_hit(16'hffff, 13'd0, 13'd0, 1'b1, 1'b0, 1'b0, z);
    send_hit(16'hfffe, 13'd0, 13'd0, 1'b0, 1'b1, 1'b0, z);
    wait_idle();

    // random part over several settings, extremes first
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(ccm_pkg::CFG_THRESHOLD, 16'd0);
          write_reg(ccm_pkg::CFG_HALF_WIDTH, 16'hfff);
        end
        1: begin
          write_reg(ccm_pkg::CFG_THRESHOLD, 16'd0);
          write_reg(ccm_pkg::CFG_HALF_WIDTH, 16'd224);
        end
        default: begin
          write_reg(ccm_pkg::CFG_THRESHOLD,
                    16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 300)));
          write_reg(ccm_pkg::CFG_HALF_WIDTH, 16'($urandom_range(0, 4095)));
        end
      endcase
      for (int n = hits_sent; hits_sent < n + 70;) random_cluster();
      wait_idle();
    end

    $display("Sent %0d hits; checked %0d cluster results (%0d without spread).",
             hits_sent, clusters_seen, invalid_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
